// ===== rtl/isort_pkg.sv =====
// Package with the payload, command and state types shared by the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none
package isort_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     final_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     end_of_set;
      logic                     overflow;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift_out;
   } cmd_type;

   typedef struct packed {
      logic last_entry;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/isort_ctrl.sv =====
// Controller state machine: collects a set, then drains it in order.
`timescale 1ns / 1ps
`default_nettype none
module isort_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_final,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire isort_pkg::status_type status,
   output isort_pkg::cmd_type         cmd
);
   import isort_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.insert    = 1'b0;
      cmd.shift_out = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.insert = 1'b1;
               if (req_final) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift_out = 1'b1;
               if (status.last_entry) begin
                  state_in = ST_COLLECT;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/isort_dp.sv =====
// Datapath: a row of sorting cells with fill count and overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module isort_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire isort_pkg::cmd_type                     cmd,
   input  wire logic signed [isort_pkg::DATA_W-1:0]    in_value,
   output isort_pkg::status_type                       status,
   output logic signed [isort_pkg::DATA_W-1:0]         head_value,
   output logic                                        dropped
);
   import isort_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic signed [DATA_W-1:0] cells_ff [DEPTH];
   logic signed [DATA_W-1:0] cells_in [DEPTH];
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     dropped_ff;
   logic                     dropped_in;
   logic [DEPTH-1:0]         gt;
   logic [DEPTH-1:0]         gt_prev;
   logic                     full;
   logic                     do_insert;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_insert = cmd.insert && !full;

   // Each cell looks at its own entry, its lower and upper neighbors, the fill count and the new value.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign gt[i] = (count_ff > CNT_W'(i)) && (cells_ff[i] > in_value);

      if (i == 0) begin : g_first
         assign gt_prev[i] = 1'b0;
      end else begin : g_rest
         assign gt_prev[i] = gt[i-1];
      end

      logic signed [DATA_W-1:0] upper_value;
      logic signed [DATA_W-1:0] insert_value;

      if (i == DEPTH - 1) begin : g_top
         assign upper_value = cells_ff[i];
      end else begin : g_mid
         assign upper_value = cells_ff[i+1];
      end

      if (i == 0) begin : g_ins0
         assign insert_value = in_value;
      end else begin : g_insn
         assign insert_value = gt_prev[i] ? cells_ff[i-1] : in_value;
      end

      always_comb begin
         cells_in[i] = cells_ff[i];
         if (cmd.shift_out) begin
            cells_in[i] = upper_value;
         end else if (do_insert && (gt[i] || (count_ff == CNT_W'(i)))) begin
            cells_in[i] = insert_value;
         end
      end

      always_ff @(posedge clock) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.shift_out) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            dropped_in = 1'b0;
         end
      end else if (cmd.insert) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign status.last_entry = (count_ff == CNT_W'(1));
   assign head_value        = cells_ff[0];
   assign dropped           = dropped_ff;

endmodule
`default_nettype wire

// ===== rtl/insertion_sorter_top.sv =====
// Top level of the streaming insertion sorter.
// Usage: values arrive on the req_ channel, one signed 32-bit value per transfer.
// Each accepted value is inserted into a row of DEPTH sorting cells in the same
// cycle, so a set streams in at one transfer per clock. A transfer with
// final_item set is inserted too, and the cycle after it the rsp_ channel starts
// to present the whole set in ascending order, one element per transfer; the
// largest element carries end_of_set. While the set drains, req_ready is low.
// A set of N elements thus passes as N input transfers and N output
// transfers; the insertion compare in every cell, against the new value, sets
// the insert position. Values that arrive when all DEPTH cells are
// occupied are dropped, and every result of that set then shows overflow.
// A stall on rsp_ready simply holds the current result; nothing shifts until the
// transfer completes. Synchronous reset empties the store and clears the
// overflow flag; cell contents are not cleared since only occupied cells are
// ever read. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module insertion_sorter_top #(
   parameter int DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire isort_pkg::req_type   req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output isort_pkg::rsp_type        rsp_data
);
   import isort_pkg::*;

   cmd_type                  cmd;
   status_type               status;
   logic signed [DATA_W-1:0] head_value;
   logic                     dropped;

   // The controller decides when to insert and when to shift the result out.
   isort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_final (req_data.final_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the set sorted at all times; the smallest is in cell 0.
   isort_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_value   (req_data.value),
      .status     (status),
      .head_value (head_value),
      .dropped    (dropped)
   );

   // Results come straight from registers, so they hold steady under a stall.
   assign rsp_data.sorted_value = head_value;
   assign rsp_data.end_of_set   = status.last_entry;
   assign rsp_data.overflow     = dropped;

endmodule
`default_nettype wire

// ===== rtl/isort_checker.sv =====
// Port-level checker for the insertion sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module isort_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire isort_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire isort_pkg::rsp_type rsp_data
);
   import isort_pkg::*;

   // Input is never taken while a sorted run is being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input accepted while results pending");

   // A final transfer starts the sorted run on the next cycle.
   a_final_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.final_item) |=> rsp_valid)
      else $error("final transfer did not start output");

   // The run ends right after its end_of_set transfer.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.end_of_set) |=> !rsp_valid)
      else $error("output continued past end of set");

   // Overflow is one flag per set and does not change inside a run.
   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.end_of_set)
         |=> (rsp_valid && (rsp_data.overflow == $past(rsp_data.overflow))))
      else $error("overflow changed within a run");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind insertion_sorter_top isort_checker u_isort_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
